[src/zph_pkg.sv]
package zph_pkg;

  localparam int unsigned BoardSquares = 64;
  localparam int unsigned PieceKinds   = 12;
  localparam int unsigned KeyCount     = BoardSquares * PieceKinds;
  localparam int unsigned KeyAw        = $clog2(KeyCount);
  localparam int unsigned WarmupRounds = 10;
  localparam logic [63:0] KeySeed      = 64'd314159;

  localparam int unsigned HashW = 64;
  localparam int unsigned SqW   = 6;
  localparam int unsigned KindW = 3;

  typedef enum logic [1:0] {
    OpClear  = 2'd0,
    OpToggle = 2'd1,
    OpMove   = 2'd2
  } op_e;

  typedef struct packed {
    logic             en;
    logic [KeyAw-1:0] addr;
  } zph_rd_req_t;

  function automatic logic [63:0] xs_next(input logic [63:0] v);
    logic [63:0] t;
    t = v ^ (v << 13);
    t = t ^ (t >> 7);
    t = t ^ (t << 17);
    return t;
  endfunction

  function automatic logic kind_valid(input logic [KindW-1:0] kind);
    return (kind != 3'd0) && (kind != 3'd7);
  endfunction

  function automatic logic [KeyAw-1:0] key_index(input logic [SqW-1:0] sq,
                                                 input logic [KindW-1:0] kind,
                                                 input logic white);
    logic [KeyAw-1:0] s;
    s = KeyAw'(sq);
    return (s << 3) + (s << 2) + KeyAw'(kind - 3'd1) + (white ? KeyAw'(6) : KeyAw'(0));
  endfunction

endpackage

[src/zph_key_mem.sv]
module zph_key_mem import zph_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  zph_rd_req_t      rd_req_i,
  output logic [HashW-1:0] rd_data_o,
  output logic             ready_o
);

  localparam int unsigned FillLen = WarmupRounds + KeyCount;
  localparam int unsigned FillCw  = $clog2(FillLen + 1);

  logic [HashW-1:0]  mem_q [KeyCount];
  logic [HashW-1:0]  rd_data_q;
  logic [FillCw-1:0] cnt_q, cnt_d;
  logic [63:0]       gen_q, gen_d;
  logic              done;
  logic              wr_en;
  logic [KeyAw-1:0]  wr_addr;

  assign done    = (cnt_q == FillCw'(FillLen));
  assign wr_en   = !done && (cnt_q >= FillCw'(WarmupRounds));
  assign wr_addr = KeyAw'(cnt_q - FillCw'(WarmupRounds));
  assign gen_d   = xs_next(gen_q);
  assign cnt_d   = done ? cnt_q : cnt_q + FillCw'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      gen_q <= KeySeed;
    end else if (!done) begin
      cnt_q <= cnt_d;
      gen_q <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= gen_d;
    end else if (rd_req_i.en) begin
      rd_data_q <= mem_q[rd_req_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = done;

`ifndef NO_ASSERTIONS
  a_no_read_during_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req_i.en |-> done)
    else $error("key read during table fill");
  a_fill_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> done)
    else $error("fill done dropped");
  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done |=> cnt_q == $past(cnt_q) + FillCw'(1))
    else $error("fill counter skipped");
`endif

endmodule

[src/zph_out_fifo.sv]
module zph_out_fifo import zph_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [HashW-1:0] push_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [HashW-1:0] position_hash_o
);

  logic [HashW-1:0] buf_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o     = (cnt_q != 2'd0);
  assign position_hash_o = buf_q[rd_ptr_q];
  assign pop             = out_valid_o && !out_stall_i;
  assign cnt_d           = cnt_q + {1'b0, push_i} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop)    rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2) || pop)
    else $error("result buffer overflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result count out of range");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_hash_o))
    else $error("stalled word changed");
`endif

endmodule

[src/zobrist_position_hash.sv]
// Zobrist position hash for an 8x8 board with 12 piece kinds.
// Input channel: in_valid_i / in_stall_o carry one word per item (op, square A
// piece, square B captured piece, square B new piece). Output channel:
// out_valid_o / out_stall_i carry the 64-bit hash as it stands after the item.
// Every item gives exactly one result word, in order.
// Cost: a move reads up to three keys from the single-port key table, one per
// cycle, so it holds the input until its last key is read; clear, toggle and the
// unused op code do not hold the input. A result is pushed into the output
// buffer as the hash register takes its final update for the item.
// With two results owed and none popped the input stalls.
// Reset: the hash clears to zero and the key table is filled from an xorshift64
// generator, 10 warm-up rounds then one key per cycle; in_stall_o stays high
// until the table is full.
// A stalled output parks up to two results in a small buffer; the input keeps
// being taken until two results are owed, then stalls.
module zobrist_position_hash import zph_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  logic [SqW-1:0]   sq_a_i,
  input  logic [KindW-1:0] kind_a_i,
  input  logic             white_a_i,
  input  logic [SqW-1:0]   sq_b_i,
  input  logic [KindW-1:0] kind_b_i,
  input  logic             white_b_i,
  input  logic [KindW-1:0] kind_new_i,
  input  logic             white_new_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [HashW-1:0] position_hash_o
);

  logic             fill_done;
  zph_rd_req_t      rd_req;
  logic [HashW-1:0] rd_data;

  logic             busy_q;
  logic [1:0]       beat_q;
  logic [1:0]       op_q;
  logic [SqW-1:0]   sq_a_q, sq_b_q;
  logic [KindW-1:0] kind_a_q, kind_b_q, kind_new_q;
  logic             white_a_q, white_b_q, white_new_q;

  logic             s1_valid_q, s1_rd_q, s1_clear_q, s1_last_q;
  logic [HashW-1:0] hash_q, hash_d;
  logic [1:0]       res_q, res_d;

  logic             accept, pop, last, push;
  logic [SqW-1:0]   beat_sq;
  logic [KindW-1:0] beat_kind;
  logic             beat_white;
  logic             uses_keys;

  assign pop    = out_valid_o && !out_stall_i;
  assign last   = (op_q != OpMove) || (beat_q == 2'd2);
  assign in_stall_o = !fill_done || (busy_q && !last) || ((res_q == 2'd2) && !pop);
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    unique case (beat_q)
      2'd0: begin
        beat_sq = sq_a_q; beat_kind = kind_a_q; beat_white = white_a_q;
      end
      2'd1: begin
        beat_sq = sq_b_q; beat_kind = kind_b_q; beat_white = white_b_q;
      end
      default: begin
        beat_sq = sq_b_q; beat_kind = kind_new_q; beat_white = white_new_q;
      end
    endcase
  end

  assign uses_keys   = (op_q == OpToggle) || (op_q == OpMove);
  assign rd_req.en   = busy_q && uses_keys && kind_valid(beat_kind);
  assign rd_req.addr = key_index(beat_sq, beat_kind, beat_white);

  zph_key_mem u_key_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_req_i (rd_req),
    .rd_data_o(rd_data),
    .ready_o  (fill_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= 2'd0;
    end else if (accept) begin
      busy_q <= 1'b1;
      beat_q <= 2'd0;
    end else if (busy_q && last) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      beat_q <= beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= op_i;
      sq_a_q      <= sq_a_i;
      kind_a_q    <= kind_a_i;
      white_a_q   <= white_a_i;
      sq_b_q      <= sq_b_i;
      kind_b_q    <= kind_b_i;
      white_b_q   <= white_b_i;
      kind_new_q  <= kind_new_i;
      white_new_q <= white_new_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_rd_q    <= 1'b0;
      s1_clear_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= busy_q;
      s1_rd_q    <= rd_req.en;
      s1_clear_q <= busy_q && (op_q == OpClear);
      s1_last_q  <= busy_q && last;
    end
  end

  always_comb begin
    hash_d = hash_q;
    if (s1_valid_q) begin
      hash_d = (s1_clear_q ? '0 : hash_q) ^ (s1_rd_q ? rd_data : '0);
    end
  end

  assign push  = s1_valid_q && s1_last_q;
  assign res_d = res_q + {1'b0, accept} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      res_q  <= 2'd0;
    end else begin
      hash_q <= hash_d;
      res_q  <= res_d;
    end
  end

  zph_out_fifo u_out_fifo (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .push_data_i    (hash_d),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .position_hash_o(position_hash_o)
  );

`ifndef NO_ASSERTIONS
  a_accept_after_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> fill_done)
    else $error("word taken before key table filled");
  a_owed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q != 2'd3)
    else $error("too many results owed");
  a_push_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> res_q != 2'd0)
    else $error("result pushed that was not owed");
  a_move_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (op_q == OpMove) && (beat_q == 2'd0) |=> busy_q && (beat_q == 2'd1))
    else $error("move beat sequence broken");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import zph_pkg::*;

  localparam logic [1:0] OpSpare = 2'd3;
  localparam int DirRows = 20;
  localparam int RandWords = 1230;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [1:0]       op;
    logic [SqW-1:0]   sq_a;
    logic [KindW-1:0] kind_a;
    logic             white_a;
    logic [SqW-1:0]   sq_b;
    logic [KindW-1:0] kind_b;
    logic             white_b;
    logic [KindW-1:0] kind_new;
    logic             white_new;
  } move_word_t;

  typedef struct packed {
    move_word_t       w;
    logic             typed;
    logic [HashW-1:0] hash;
  } board_row_t;

  localparam board_row_t BoardRows [DirRows] = '{
    '{'{OpSpare,  6'd0,  3'd0, 1'b0, 6'd0,  3'd0, 1'b0, 3'd0, 1'b0}, 1'b1, 64'd0},
    '{'{OpClear,  6'd0,  3'd0, 1'b0, 6'd0,  3'd0, 1'b0, 3'd0, 1'b0}, 1'b1, 64'd0},
    '{'{OpToggle, 6'd0,  3'd0, 1'b0, 6'd0,  3'd0, 1'b0, 3'd0, 1'b0}, 1'b1, 64'd0},
    '{'{OpToggle, 6'd63, 3'd7, 1'b1, 6'd63, 3'd7, 1'b1, 3'd7, 1'b1}, 1'b1, 64'd0},
    '{'{OpToggle, 6'd0,  3'd1, 1'b0, 6'd0,  3'd0, 1'b0, 3'd0, 1'b0}, 1'b0, 64'd0},
    '{'{OpToggle, 6'd0,  3'd1, 1'b0, 6'd0,  3'd0, 1'b0, 3'd0, 1'b0}, 1'b1, 64'd0},
    '{'{OpToggle, 6'd63, 3'd6, 1'b1, 6'd0,  3'd0, 1'b0, 3'd0, 1'b0}, 1'b0, 64'd0},
    '{'{OpToggle, 6'd63, 3'd6, 1'b1, 6'd0,  3'd0, 1'b0, 3'd0, 1'b0}, 1'b1, 64'd0},
    '{'{OpMove,   6'd12, 3'd1, 1'b1, 6'd28, 3'd0, 1'b0, 3'd1, 1'b1}, 1'b0, 64'd0},
    '{'{OpMove,   6'd28, 3'd1, 1'b1, 6'd35, 3'd3, 1'b0, 3'd1, 1'b1}, 1'b0, 64'd0},
    '{'{OpMove,   6'd48, 3'd1, 1'b1, 6'd56, 3'd0, 1'b0, 3'd5, 1'b1}, 1'b0, 64'd0},
    '{'{OpMove,   6'd21, 3'd7, 1'b1, 6'd42, 3'd7, 1'b0, 3'd7, 1'b1}, 1'b0, 64'd0},
    '{'{OpMove,   6'd0,  3'd6, 1'b0, 6'd63, 3'd6, 1'b1, 3'd6, 1'b0}, 1'b0, 64'd0},
    '{'{OpSpare,  6'd63, 3'd5, 1'b1, 6'd63, 3'd6, 1'b1, 3'd4, 1'b1}, 1'b0, 64'd0},
    '{'{OpToggle, 6'd63, 3'd3, 1'b0, 6'd17, 3'd2, 1'b1, 3'd6, 1'b1}, 1'b0, 64'd0},
    '{'{OpMove,   6'd9,  3'd4, 1'b0, 6'd9,  3'd2, 1'b1, 3'd4, 1'b0}, 1'b0, 64'd0},
    '{'{OpClear,  6'd5,  3'd3, 1'b1, 6'd7,  3'd2, 1'b1, 3'd1, 1'b1}, 1'b1, 64'd0},
    '{'{OpMove,   6'd0,  3'd0, 1'b0, 6'd0,  3'd0, 1'b0, 3'd0, 1'b0}, 1'b1, 64'd0},
    '{'{OpToggle, 6'd42, 3'd2, 1'b1, 6'd0,  3'd0, 1'b0, 3'd0, 1'b0}, 1'b0, 64'd0},
    '{'{OpClear,  6'd63, 3'd7, 1'b1, 6'd63, 3'd7, 1'b1, 3'd7, 1'b1}, 1'b1, 64'd0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       op = '0;
  logic [SqW-1:0]   sq_a = '0;
  logic [KindW-1:0] kind_a = '0;
  logic             white_a = 1'b0;
  logic [SqW-1:0]   sq_b = '0;
  logic [KindW-1:0] kind_b = '0;
  logic             white_b = 1'b0;
  logic [KindW-1:0] kind_new = '0;
  logic             white_new = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [HashW-1:0] position_hash;

  logic [HashW-1:0] key_bank [KeyCount];
  logic [HashW-1:0] board_hash;
  logic [HashW-1:0] hash_queue [$];
  int               fail_count = 0;
  int               words_sent = 0;
  int               hashes_seen = 0;
  int               cycle_count = 0;

  zobrist_position_hash u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .sq_a_i         (sq_a),
    .kind_a_i       (kind_a),
    .white_a_i      (white_a),
    .sq_b_i         (sq_b),
    .kind_b_i       (kind_b),
    .white_b_i      (white_b),
    .kind_new_i     (kind_new),
    .white_new_i    (white_new),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .position_hash_o(position_hash)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [HashW-1:0] roll_key(input logic [HashW-1:0] v);
    logic [HashW-1:0] t;
    t = v ^ (v << 13);
    t = t ^ (t >> 7);
    return t ^ (t << 17);
  endfunction

  function automatic logic [HashW-1:0] piece_code(input logic [SqW-1:0] sq,
                                                  input logic [KindW-1:0] kind,
                                                  input logic white);
    int slot;
    if (kind == 3'd0 || kind == 3'd7) return '0;
    slot = int'(sq) * PieceKinds + int'(kind) - 1 + (white ? 6 : 0);
    return key_bank[slot];
  endfunction

  function automatic logic [HashW-1:0] next_hash(input logic [HashW-1:0] h,
                                                 input move_word_t w);
    case (w.op)
      OpClear:  return '0;
      OpToggle: return h ^ piece_code(w.sq_a, w.kind_a, w.white_a);
      OpMove:   return h ^ piece_code(w.sq_a, w.kind_a, w.white_a)
                         ^ piece_code(w.sq_b, w.kind_b, w.white_b)
                         ^ piece_code(w.sq_b, w.kind_new, w.white_new);
      default:  return h;
    endcase
  endfunction

  function automatic logic [KindW-1:0] draw_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 3'd0;
    if (r == 1) return 3'd7;
    return KindW'($urandom_range(1, 6));
  endfunction

  function automatic move_word_t draw_word();
    move_word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) w.op = OpClear;
    else if (r < 36) w.op = OpToggle;
    else if (r < 94) w.op = OpMove;
    else w.op = OpSpare;
    w.sq_a = SqW'($urandom_range(0, 63));
    w.kind_a = draw_kind();
    w.white_a = 1'($urandom_range(0, 1));
    w.sq_b = SqW'($urandom_range(0, 63));
    w.kind_b = draw_kind();
    w.white_b = 1'($urandom_range(0, 1));
    w.kind_new = draw_kind();
    w.white_new = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic bit calm_stretch(input int n);
    return (n >= 400 && n < 500);
  endfunction

  task automatic send_word(input move_word_t w, input bit typed,
                           input logic [HashW-1:0] typed_hash);
    int gap;
    gap = calm_stretch(words_sent) ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op <= w.op;
    sq_a <= w.sq_a;
    kind_a <= w.kind_a;
    white_a <= w.white_a;
    sq_b <= w.sq_b;
    kind_b <= w.kind_b;
    white_b <= w.white_b;
    kind_new <= w.kind_new;
    white_new <= w.white_new;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    board_hash = next_hash(board_hash, w);
    hash_queue.push_back(typed ? typed_hash : board_hash);
    words_sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      hashes_seen <= hashes_seen + 1;
      if (hash_queue.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %h", $time, position_hash);
        fail_count++;
      end else begin
        if (position_hash !== hash_queue[0]) begin
          $display("%0t: position_hash mismatch: expected %h, actual %h",
                   $time, hash_queue[0], position_hash);
          fail_count++;
        end
        void'(hash_queue.pop_front());
      end
    end
  end

  initial begin
    int wait_left;
    int last_seen;
    bit held;
    wait_left = 0;
    last_seen = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hashes_seen != last_seen) begin
        last_seen = hashes_seen;
        if (!held && hashes_seen >= 200) begin
          held = 1'b1;
          wait_left = 300;
        end else begin
          wait_left = calm_stretch(hashes_seen) ? 0 : $urandom_range(0, 11);
        end
      end
      if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [HashW-1:0] v;
    v = KeySeed;
    for (int i = 0; i < WarmupRounds; i++) v = roll_key(v);
    for (int i = 0; i < KeyCount; i++) begin
      v = roll_key(v);
      key_bank[i] = v;
    end
    board_hash = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      send_word(BoardRows[i].w, BoardRows[i].typed, BoardRows[i].hash);
    end

    for (int i = 0; i < RandWords; i++) begin
      if (i == 600) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        while (hash_queue.size() != 0) @(posedge clk_i);
      end
      send_word(draw_word(), 1'b0, '0);
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    while (hash_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && hash_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
src/zph_pkg.sv
src/zph_key_mem.sv
src/zph_out_fifo.sv
src/zobrist_position_hash.sv
bench/tb_top.sv
